/* sv/scp_pkg.sv */
// Shared types and constants for the second-chance page replacement block.
package scp_pkg;

  localparam int FRAME_COUNT = 4;
  localparam int PAGE_BITS   = 8;
  localparam int FRAME_BITS  = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int FAULT_BITS  = 16;

  localparam logic [FRAME_BITS-1:0] LAST_FRAME = FRAME_BITS'(FRAME_COUNT - 1);
  localparam logic [FAULT_BITS-1:0] FAULT_MAX  = {FAULT_BITS{1'b1}};

  // Controller to datapath commands.
  typedef struct packed {
    logic latch_in;
    logic lookup;
    logic scan_step;
    logic commit;
  } scp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic hit;
    logic free_found;
    logic ref_at_hand;
    logic out_free;
  } scp_sts_t;

endpackage

/* sv/scp_ctrl.sv */
// Controller state machine: sequences lookup, victim scan and commit.
module scp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  scp_pkg::scp_sts_t sts,
  output scp_pkg::scp_cmd_t cmd
);
  import scp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_LOOKUP = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
        if (in_valid) state_next = S_LOOKUP;
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = (sts.hit || sts.free_found) ? S_FINISH : S_SCAN;
      end
      S_SCAN: begin
        // Clear a set bit and advance, or take the frame under the hand.
        cmd.scan_step = 1'b1;
        if (!sts.ref_at_hand) state_next = S_FINISH;
      end
      S_FINISH: begin
        // Hold until the output slot can take the result beat.
        cmd.commit = sts.out_free;
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* sv/scp_datapath.sv */
// Datapath: frame tags, valid and reference bits, clock hand, fault counter, result register.
module scp_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  scp_pkg::scp_cmd_t     cmd,
  output scp_pkg::scp_sts_t     sts,
  input  logic [7:0]            page_number,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic                  hit,
  output logic [1:0]            frame_index,
  output logic                  evicted_valid,
  output logic [7:0]            evicted_page,
  output logic [15:0]           fault_total
);
  import scp_pkg::*;

  logic [PAGE_BITS-1:0]   frame_tag [FRAME_COUNT];
  logic [FRAME_COUNT-1:0] frame_valid;
  logic [FRAME_COUNT-1:0] reference_bit;
  logic [FRAME_BITS-1:0]  clock_hand;
  logic [FAULT_BITS-1:0]  fault_counter;

  logic [PAGE_BITS-1:0]   page;
  logic                   hit_q;
  logic                   evict_q;
  logic [FRAME_BITS-1:0]  frame_q;
  logic [PAGE_BITS-1:0]   evict_tag;

  logic                   hit_any;
  logic [FRAME_BITS-1:0]  hit_frame;
  logic                   free_any;
  logic [FRAME_BITS-1:0]  free_frame;
  logic [FRAME_BITS-1:0]  hand_next;
  logic [FAULT_BITS-1:0]  fault_next;

  // Priority search: lowest-numbered match and lowest-numbered empty frame.
  always_comb begin
    hit_any    = 1'b0;
    hit_frame  = '0;
    free_any   = 1'b0;
    free_frame = '0;
    for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
      if (frame_valid[i] && frame_tag[i] == page) begin
        hit_any   = 1'b1;
        hit_frame = FRAME_BITS'(i);
      end
      if (!frame_valid[i]) begin
        free_any   = 1'b1;
        free_frame = FRAME_BITS'(i);
      end
    end
  end

  assign hand_next  = (clock_hand == LAST_FRAME) ? '0 : clock_hand + 1'b1;
  assign fault_next = (!hit_q && fault_counter != FAULT_MAX) ?
                      fault_counter + 1'b1 : fault_counter;

  assign sts.hit         = hit_any;
  assign sts.free_found  = free_any;
  assign sts.ref_at_hand = reference_bit[clock_hand];
  assign sts.out_free    = !out_valid || out_ready;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid   <= '0;
      reference_bit <= '0;
      clock_hand    <= '0;
      fault_counter <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.scan_step && reference_bit[clock_hand]) begin
        reference_bit[clock_hand] <= 1'b0;
        clock_hand                <= hand_next;
      end
      if (cmd.commit) begin
        fault_counter <= fault_next;
        if (hit_q) begin
          reference_bit[frame_q] <= 1'b1;
        end else begin
          frame_valid[frame_q]   <= 1'b1;
          reference_bit[frame_q] <= 1'b0;
        end
        if (evict_q) clock_hand <= hand_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Tags reset to zero to match the cleared store.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FRAME_COUNT; i++) frame_tag[i] <= '0;
    end else if (cmd.commit && !hit_q) begin
      frame_tag[frame_q] <= page;
    end
  end

  // Per-item working registers and the result register.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) page <= PAGE_BITS'(page_number);
    if (cmd.lookup) begin
      hit_q   <= hit_any;
      evict_q <= 1'b0;
      frame_q <= hit_any ? hit_frame : free_frame;
    end
    if (cmd.scan_step && !reference_bit[clock_hand]) begin
      evict_q   <= 1'b1;
      frame_q   <= clock_hand;
      evict_tag <= frame_tag[clock_hand];
    end
    if (cmd.commit) begin
      hit           <= hit_q;
      frame_index   <= 2'(frame_q);
      evicted_valid <= evict_q;
      evicted_page  <= evict_q ? 8'(evict_tag) : 8'd0;
      fault_total   <= 16'(fault_next);
    end
  end

endmodule

/* sv/second_chance_page_replacement_top.sv */
// One reference at a time; the next beat is taken once the result is committed.
// The victim scan visits one frame per cycle through the clock hand (FRAME_COUNT + 1 max).
// A finished result waits in the output register while the next beat is accepted.
// Reset (rst, synchronous, active high) empties all frames, clears reference bits,
// puts the hand at frame zero and zeroes the fault counter; no clearing pass is needed.
module second_chance_page_replacement_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  page_number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        hit,
  output logic [1:0]  frame_index,
  output logic        evicted_valid,
  output logic [7:0]  evicted_page,
  output logic [15:0] fault_total
);
  import scp_pkg::*;

  scp_cmd_t cmd;
  scp_sts_t sts;

  // Controller: accept a beat, look it up, scan for a victim, commit.
  scp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: frame store, clock hand, fault counter and the result register.
  scp_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .page_number   (page_number),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .hit           (hit),
    .frame_index   (frame_index),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_total   (fault_total)
  );

`ifndef NO_ASSERTIONS
  // A hit never evicts anything.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> !evicted_valid) else $error("eviction reported on a hit");

  // No eviction means a zero evicted page.
  a_evict_page_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !evicted_valid |-> evicted_page == 8'd0)
    else $error("evicted page nonzero without eviction");

  // One reference at a time: after an accepted beat the input closes.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("second beat taken while busy");

  // Reset empties the output register.
  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("result valid after reset");
`endif

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the second-chance page replacement block.
module tb;
  import scp_pkg::*;

  // Shape of one result beat, in port order.
  typedef struct packed {
    logic        hit;
    logic [1:0]  frame_index;
    logic        evicted_valid;
    logic [7:0]  evicted_page;
    logic [15:0] fault_total;
  } page_result_t;

  // Track the frame table, predict each reference and check results in order.
  class page_ref_scoreboard;
    logic [PAGE_BITS-1:0]  frame_tags [FRAME_COUNT];
    bit                    resident [FRAME_COUNT];
    bit                    second_chance [FRAME_COUNT];
    int unsigned           hand;
    logic [FAULT_BITS-1:0] faults;
    page_result_t          awaited_results [$];
    int unsigned           fail_count;

    function new();
      foreach (frame_tags[i]) begin
        frame_tags[i]    = '0;
        resident[i]      = 1'b0;
        second_chance[i] = 1'b0;
      end
      hand       = 0;
      faults     = '0;
      fail_count = 0;
    endfunction

    // Print one line per mismatch and count every one.
    function void report(input string msg);
      fail_count++;
      $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    // Apply one accepted reference to the frame table and queue its result.
    function void note_page(input logic [7:0] pg);
      logic [PAGE_BITS-1:0] tag;
      page_result_t         r;
      bit                   found;
      bit                   free_slot;
      int unsigned          frame;
      int unsigned          h;
      tag       = PAGE_BITS'(pg);
      r         = '0;
      found     = 1'b0;
      free_slot = 1'b0;
      frame     = 0;
      // Lowest-numbered resident frame with a matching tag wins.
      for (int i = 0; i < FRAME_COUNT; i++) begin
        if (!found && resident[i] && frame_tags[i] == tag) begin
          found = 1'b1;
          frame = i;
        end
      end
      if (found) begin
        second_chance[frame] = 1'b1;
        r.hit = 1'b1;
      end else begin
        if (faults != FAULT_MAX) faults++;
        for (int i = 0; i < FRAME_COUNT; i++) begin
          if (!free_slot && !resident[i]) begin
            free_slot = 1'b1;
            frame     = i;
          end
        end
        if (!free_slot) begin
          // Sweep from the hand, clearing set bits until a clear one turns up.
          h = hand;
          for (int s = 0; s <= FRAME_COUNT && second_chance[h]; s++) begin
            second_chance[h] = 1'b0;
            h = (h + 1 == FRAME_COUNT) ? 0 : h + 1;
          end
          frame           = h;
          r.evicted_valid = 1'b1;
          r.evicted_page  = 8'(frame_tags[h]);
          hand            = (h + 1 == FRAME_COUNT) ? 0 : h + 1;
        end
        frame_tags[frame]    = tag;
        resident[frame]      = 1'b1;
        second_chance[frame] = 1'b0;
      end
      r.frame_index = 2'(frame);
      r.fault_total = faults;
      awaited_results.push_back(r);
    endfunction

    // Compare one result beat against the oldest prediction.
    function void check_result(input page_result_t got);
      page_result_t want;
      if (awaited_results.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      want = awaited_results.pop_front();
      if (got.hit !== want.hit)
        report($sformatf("hit got %b want %b", got.hit, want.hit));
      if (got.frame_index !== want.frame_index)
        report($sformatf("frame_index got %0d want %0d", got.frame_index, want.frame_index));
      if (got.evicted_valid !== want.evicted_valid)
        report($sformatf("evicted_valid got %b want %b",
                         got.evicted_valid, want.evicted_valid));
      if (got.evicted_page !== want.evicted_page)
        report($sformatf("evicted_page got %0d want %0d",
                         got.evicted_page, want.evicted_page));
      if (got.fault_total !== want.fault_total)
        report($sformatf("fault_total got %0d want %0d", got.fault_total, want.fault_total));
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction
  endclass

  localparam int          RANDOM_REFS    = 1030;
  localparam int          PAUSE_AT_REF   = 500;  // sender drains the block here
  localparam int          LONG_HOLD_AT   = 300;  // receiver holds off at this result
  localparam int          LONG_HOLD_LEN  = 48;
  localparam int          DRAIN_LIMIT    = 5000;
  localparam int          SETTLE_CYCLES  = 16;

  // Directed opening: extremes of the page field, fills of empty frames, hits,
  // the sweep with every reference bit set, and evictions from the middle.
  localparam logic [7:0] OPENING [20] = '{
    8'd0, 8'd255, 8'd0, 8'd170, 8'd85, 8'd255, 8'd170, 8'd85, 8'd1, 8'd0,
    8'd2, 8'd3, 8'd2, 8'd3, 8'd0, 8'd1, 8'd4, 8'd254, 8'd128, 8'd127
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  page_number = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        hit;
  logic [1:0]  frame_index;
  logic        evicted_valid;
  logic [7:0]  evicted_page;
  logic [15:0] fault_total;

  page_ref_scoreboard sb = new();
  bit                 gaps_on = 1'b1;   // both sides idle at random while set
  int unsigned        results_seen = 0;

  second_chance_page_replacement_top dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .page_number   (page_number),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit           (hit),
    .frame_index   (frame_index),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_total   (fault_total)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Offer one reference after a gap and hold it until the beat is taken.
  // Called at a falling edge; returns at the falling edge after acceptance.
  // Only one assignment to in_valid lands per step, so back-to-back beats
  // keep valid high without a glitch.
  task automatic send_page(input logic [7:0] pg, input int unsigned gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    page_number <= pg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_page(pg);
    @(negedge clk);
  endtask

  // Sender: reset, directed opening, then random working sets.
  initial begin : stimulus
    logic [7:0]  base;
    logic [7:0]  pg;
    int unsigned drained;
    base    = 8'd0;
    drained = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (OPENING[i]) send_page(OPENING[i], gaps_on ? $urandom_range(0, 3) : 0);

    for (int n = 0; n < RANDOM_REFS; n++) begin
      // Alternate stretches with and without idling.
      if (n % 128 == 64) gaps_on = ~gaps_on;
      // Move the working set now and then so evictions and hits both stay common.
      if (n % 48 == 0) base = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 15)
        pg = 8'($urandom_range(0, 255));
      else
        pg = base + 8'($urandom_range(0, 5));
      if (n == PAUSE_AT_REF) begin
        // Drop valid and wait for every outstanding result before going on.
        in_valid <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
      end
      send_page(pg, gaps_on ? $urandom_range(0, 3) : 0);
    end
    in_valid <= 1'b0;

    // Wait for the tail, then keep running to catch strays.
    while (sb.pending() != 0 && drained < DRAIN_LIMIT) begin
      @(negedge clk);
      drained++;
    end
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (sb.fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Receiver: stall at random before each beat while gaps_on is set, with one long
  // hold-off that lets the block fill and push back on the sender.
  initial begin : sink
    int unsigned stall;
    page_result_t got;
    while (rst) @(negedge clk);
    forever begin
      stall = gaps_on ? $urandom_range(0, 3) : 0;
      if (results_seen == LONG_HOLD_AT) stall = LONG_HOLD_LEN;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got = '{hit, frame_index, evicted_valid, evicted_page, fault_total};
      sb.check_result(got);
      results_seen++;
      @(negedge clk);
    end
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #(64'd2_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
